/* hw/rtl/wpi_pkg.sv */
// shared widths, register indexes, codes and reset values of the wipe/push/iris pixel selector
package wpi_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  localparam int MODE_BITS     = 3;
  localparam int PROG_BITS     = 14;
  localparam int DIMREG_BITS   = 13;
  localparam int PERMILLE_BITS = 10;
  localparam int THICK_BITS    = 8;
  localparam int COLOR_BITS    = 16;
  localparam int SEL_BITS      = 2;

  localparam int PROG_FULL     = 10000;
  localparam int PERMILLE_FULL = 1000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE     = 4'd0,
    REG_PROGRESS = 4'd1,
    REG_WIDTH    = 4'd2,
    REG_HEIGHT   = 4'd3,
    REG_CENTER_X = 4'd4,
    REG_CENTER_Y = 4'd5,
    REG_THICK    = 4'd6,
    REG_COLOR    = 4'd7
  } reg_index_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_IRIS    = 3'd0,
    MODE_SLIDE_H = 3'd1,
    MODE_SLIDE_V = 3'd2,
    MODE_PUSH_H  = 3'd3,
    MODE_PUSH_V  = 3'd4
  } mode_t;

  typedef enum logic [SEL_BITS-1:0] {
    SEL_A      = 2'd0,
    SEL_B      = 2'd1,
    SEL_BORDER = 2'd2
  } sel_t;

  localparam logic [PROG_BITS-1:0]     RST_PROGRESS = 14'd0;
  localparam logic [DIMREG_BITS-1:0]   RST_WIDTH    = 13'd640;
  localparam logic [DIMREG_BITS-1:0]   RST_HEIGHT   = 13'd480;
  localparam logic [PERMILLE_BITS-1:0] RST_CENTER   = 10'd500;
  localparam logic [THICK_BITS-1:0]    RST_THICK    = 8'd2;
  localparam logic [COLOR_BITS-1:0]    RST_COLOR    = 16'd0;

endpackage

/* hw/rtl/wpi_cfg_if.sv */
// configuration write channel: register index and data with valid/ready
interface wpi_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wpi_pkg::CFG_INDEX_BITS-1:0] index;
  logic [wpi_pkg::CFG_DATA_BITS-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/wpi_pixel_if.sv */
// destination pixel coordinate channel with valid/ready
interface wpi_pixel_if #(
  parameter int COORD_BITS = wpi_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;

  modport source(output valid, pixel_col, pixel_row, input ready);
  modport sink(input valid, pixel_col, pixel_row, output ready);
endinterface

/* hw/rtl/wpi_result_if.sv */
// pixel source decision channel with valid/ready
interface wpi_result_if #(
  parameter int COORD_BITS = wpi_pkg::COORD_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [wpi_pkg::SEL_BITS-1:0]     source_select;
  logic [COORD_BITS-1:0]            source_col;
  logic [COORD_BITS-1:0]            source_row;
  logic [wpi_pkg::COLOR_BITS-1:0]   fill_pixel;

  modport source(output valid, source_select, source_col, source_row, fill_pixel, input ready);
  modport sink(input valid, source_select, source_col, source_row, fill_pixel, output ready);
endinterface

/* hw/rtl/wipe_push_iris_pixel_selector_top.sv */
// Transition pixel selector: one destination pixel per clock in, one source decision per clock
// out while the geometry sequencer is idle and no result is stalled. A pixel passes an input
// register, then the result register, which holds a stalled result while the next pixel waits
// in the input register. The frame geometry (iris centre, box origin and size, slide offsets)
// is worked out from the configuration registers by one shared multiplier and reciprocal-divide
// sequencer, six quantities by multiply, reciprocal and fix-up steps, then a finishing step;
// pixels.ready is low while it runs, after reset and every configuration write; cfg is always ready.
module wipe_push_iris_pixel_selector_top #(
  parameter int COORD_BITS = wpi_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  wpi_cfg_if.sink      cfg,
  wpi_pixel_if.sink    pixels,
  wpi_result_if.source results
);

  localparam int DIM_BITS  = COORD_BITS + 1;
  localparam int EXT_BITS  = DIM_BITS + 1;
  localparam int CMP_BITS  = (DIM_BITS > wpi_pkg::DIMREG_BITS) ? DIM_BITS : wpi_pkg::DIMREG_BITS;
  localparam int PROD_BITS = wpi_pkg::PROG_BITS + DIM_BITS;
  localparam int SHIFT     = PROD_BITS;

  localparam logic [PROD_BITS-1:0] RECIP_PROG =
    PROD_BITS'((64'd1 << SHIFT) / wpi_pkg::PROG_FULL);
  localparam logic [PROD_BITS-1:0] RECIP_PERMILLE =
    PROD_BITS'((64'd1 << SHIFT) / wpi_pkg::PERMILLE_FULL);

  typedef enum logic [2:0] {
    OP_CX, OP_CY, OP_BW, OP_BH, OP_BX, OP_BY, OP_FIN
  } op_t;

  typedef enum logic [1:0] {
    PH_MUL, PH_RECIP, PH_FIX
  } phase_t;

  // configuration registers
  wpi_pkg::mode_t                      transition_mode;
  logic [wpi_pkg::PROG_BITS-1:0]       progress;
  logic [wpi_pkg::DIMREG_BITS-1:0]     frame_width;
  logic [wpi_pkg::DIMREG_BITS-1:0]     frame_height;
  logic [wpi_pkg::PERMILLE_BITS-1:0]   center_x_permille;
  logic [wpi_pkg::PERMILLE_BITS-1:0]   center_y_permille;
  logic [wpi_pkg::THICK_BITS-1:0]      border_thickness;
  logic [wpi_pkg::COLOR_BITS-1:0]      border_color;

  logic cfg_fire;

  // saturated views
  logic [DIM_BITS-1:0]               w_dim;
  logic [DIM_BITS-1:0]               h_dim;
  logic [wpi_pkg::PROG_BITS-1:0]     p_sat;
  logic [wpi_pkg::PERMILLE_BITS-1:0] cx_sat;
  logic [wpi_pkg::PERMILLE_BITS-1:0] cy_sat;

  // geometry sequencer
  logic                          busy;
  op_t                           op;
  phase_t                        phase;
  logic [PROD_BITS-1:0]          prod;
  logic [PROD_BITS-1:0]          quot_est;
  logic [wpi_pkg::PROG_BITS-1:0] mul_a;
  logic [DIM_BITS-1:0]           mul_b;
  logic                          div_permille;
  logic [PROD_BITS-1:0]          prod_next;
  logic [PROD_BITS-1:0]          recip;
  logic [2*PROD_BITS-1:0]        recip_prod;
  logic [PROD_BITS:0]            back_mul;
  logic [PROD_BITS:0]            back_next;
  logic [PROD_BITS-1:0]          quot_fix;

  logic [DIM_BITS-1:0] cx_pos;
  logic [DIM_BITS-1:0] cy_pos;
  logic [DIM_BITS-1:0] box_w;
  logic [DIM_BITS-1:0] box_h;
  logic [DIM_BITS-1:0] box_x;
  logic [DIM_BITS-1:0] box_y;
  logic [DIM_BITS-1:0] x_end;
  logic [DIM_BITS-1:0] y_end;
  logic [EXT_BITS-1:0] x_lo;
  logic [EXT_BITS-1:0] y_lo;
  logic [DIM_BITS-1:0] w_rem;
  logic [DIM_BITS-1:0] h_rem;

  // pixel pipeline
  logic                  s1_valid;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic                  out_valid;
  logic                  adv_out;
  logic                  adv_s1;
  logic                  in_fire;

  wpi_pkg::sel_t                   out_sel;
  logic [COORD_BITS-1:0]           out_col;
  logic [COORD_BITS-1:0]           out_row;
  logic [wpi_pkg::COLOR_BITS-1:0]  out_fill;

  wpi_pkg::sel_t         sel_c;
  logic [COORD_BITS-1:0] sc_c;
  logic [COORD_BITS-1:0] sr_c;
  logic [DIM_BITS-1:0]   col_d;
  logic [DIM_BITS-1:0]   row_d;
  logic [EXT_BITS-1:0]   col_e;
  logic [EXT_BITS-1:0]   row_e;
  logic [EXT_BITS-1:0]   t_e;
  logic                  in_frame;
  logic                  in_box;
  logic                  on_band;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [wpi_pkg::DIMREG_BITS-1:0] v);
    logic [CMP_BITS-1:0] ext;
    logic [CMP_BITS-1:0] top;
    ext = CMP_BITS'(v);
    top = CMP_BITS'(1) << COORD_BITS;
    if (ext == '0) begin
      clamp_dim = DIM_BITS'(1);
    end else if (ext > top) begin
      clamp_dim = DIM_BITS'(top);
    end else begin
      clamp_dim = DIM_BITS'(ext);
    end
  endfunction

  // configuration port
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_mode   <= wpi_pkg::MODE_IRIS;
      progress          <= wpi_pkg::RST_PROGRESS;
      frame_width       <= wpi_pkg::RST_WIDTH;
      frame_height      <= wpi_pkg::RST_HEIGHT;
      center_x_permille <= wpi_pkg::RST_CENTER;
      center_y_permille <= wpi_pkg::RST_CENTER;
      border_thickness  <= wpi_pkg::RST_THICK;
      border_color      <= wpi_pkg::RST_COLOR;
    end else if (cfg_fire) begin
      case (wpi_pkg::reg_index_t'(cfg.index))
        wpi_pkg::REG_MODE: begin
          transition_mode <= wpi_pkg::mode_t'(cfg.data[wpi_pkg::MODE_BITS-1:0]);
        end
        wpi_pkg::REG_PROGRESS: progress <= cfg.data[wpi_pkg::PROG_BITS-1:0];
        wpi_pkg::REG_WIDTH:    frame_width <= cfg.data[wpi_pkg::DIMREG_BITS-1:0];
        wpi_pkg::REG_HEIGHT:   frame_height <= cfg.data[wpi_pkg::DIMREG_BITS-1:0];
        wpi_pkg::REG_CENTER_X: center_x_permille <= cfg.data[wpi_pkg::PERMILLE_BITS-1:0];
        wpi_pkg::REG_CENTER_Y: center_y_permille <= cfg.data[wpi_pkg::PERMILLE_BITS-1:0];
        wpi_pkg::REG_THICK:    border_thickness <= cfg.data[wpi_pkg::THICK_BITS-1:0];
        wpi_pkg::REG_COLOR:    border_color <= cfg.data[wpi_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_dim  = clamp_dim(frame_width);
    h_dim  = clamp_dim(frame_height);
    p_sat  = (progress > wpi_pkg::PROG_BITS'(wpi_pkg::PROG_FULL)) ?
             wpi_pkg::PROG_BITS'(wpi_pkg::PROG_FULL) : progress;
    cx_sat = (center_x_permille > wpi_pkg::PERMILLE_BITS'(wpi_pkg::PERMILLE_FULL)) ?
             wpi_pkg::PERMILLE_BITS'(wpi_pkg::PERMILLE_FULL) : center_x_permille;
    cy_sat = (center_y_permille > wpi_pkg::PERMILLE_BITS'(wpi_pkg::PERMILLE_FULL)) ?
             wpi_pkg::PERMILLE_BITS'(wpi_pkg::PERMILLE_FULL) : center_y_permille;
  end

  // operand select for the shared multiply / divide-by-constant unit
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_permille = 1'b0;
    case (op)
      OP_CX: begin
        mul_a        = wpi_pkg::PROG_BITS'(cx_sat);
        mul_b        = w_dim;
        div_permille = 1'b1;
      end
      OP_CY: begin
        mul_a        = wpi_pkg::PROG_BITS'(cy_sat);
        mul_b        = h_dim;
        div_permille = 1'b1;
      end
      OP_BW: begin
        mul_a = p_sat;
        mul_b = w_dim;
      end
      OP_BH: begin
        mul_a = p_sat;
        mul_b = h_dim;
      end
      OP_BX: begin
        mul_a = wpi_pkg::PROG_BITS'(wpi_pkg::PROG_FULL) - p_sat;
        mul_b = cx_pos;
      end
      OP_BY: begin
        mul_a = wpi_pkg::PROG_BITS'(wpi_pkg::PROG_FULL) - p_sat;
        mul_b = cy_pos;
      end
      default: ;
    endcase
  end

  assign prod_next  = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  assign recip      = div_permille ? RECIP_PERMILLE : RECIP_PROG;
  assign recip_prod = (2 * PROD_BITS)'(prod) * (2 * PROD_BITS)'(recip);

  // the floor reciprocal undershoots by at most one: bump when one more divisor still fits
  always_comb begin
    if (div_permille) begin
      back_mul  = (PROD_BITS + 1)'(quot_est) * (PROD_BITS + 1)'(wpi_pkg::PERMILLE_FULL);
      back_next = back_mul + (PROD_BITS + 1)'(wpi_pkg::PERMILLE_FULL);
    end else begin
      back_mul  = (PROD_BITS + 1)'(quot_est) * (PROD_BITS + 1)'(wpi_pkg::PROG_FULL);
      back_next = back_mul + (PROD_BITS + 1)'(wpi_pkg::PROG_FULL);
    end
    quot_fix = quot_est + PROD_BITS'(back_next <= (PROD_BITS + 1)'(prod));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      op    <= OP_CX;
      phase <= PH_MUL;
    end else if (cfg_fire) begin
      busy  <= 1'b1;
      op    <= OP_CX;
      phase <= PH_MUL;
    end else if (busy) begin
      if (op == OP_FIN) begin
        x_end <= box_x + box_w;
        y_end <= box_y + box_h;
        x_lo  <= EXT_BITS'(box_x) + EXT_BITS'(border_thickness);
        y_lo  <= EXT_BITS'(box_y) + EXT_BITS'(border_thickness);
        w_rem <= w_dim - box_w;
        h_rem <= h_dim - box_h;
        busy  <= 1'b0;
      end else begin
        case (phase)
          PH_MUL: begin
            prod  <= prod_next;
            phase <= PH_RECIP;
          end
          PH_RECIP: begin
            quot_est <= recip_prod[2*PROD_BITS-1:SHIFT];
            phase    <= PH_FIX;
          end
          PH_FIX: begin
            phase <= PH_MUL;
            case (op)
              OP_CX: begin
                cx_pos <= quot_fix[DIM_BITS-1:0];
                op     <= OP_CY;
              end
              OP_CY: begin
                cy_pos <= quot_fix[DIM_BITS-1:0];
                op     <= OP_BW;
              end
              OP_BW: begin
                box_w <= quot_fix[DIM_BITS-1:0];
                op    <= OP_BH;
              end
              OP_BH: begin
                box_h <= quot_fix[DIM_BITS-1:0];
                op    <= OP_BX;
              end
              OP_BX: begin
                box_x <= quot_fix[DIM_BITS-1:0];
                op    <= OP_BY;
              end
              OP_BY: begin
                box_y <= quot_fix[DIM_BITS-1:0];
                op    <= OP_FIN;
              end
              default: op <= OP_FIN;
            endcase
          end
          default: phase <= PH_MUL;
        endcase
      end
    end
  end

  // pixel pipeline handshake
  assign adv_out      = !out_valid || results.ready;
  assign adv_s1       = !s1_valid || adv_out;
  assign pixels.ready = adv_s1 && !busy;
  assign in_fire      = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid <= in_fire;
      end
      if (adv_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  // per-pixel decision
  always_comb begin
    col_d    = DIM_BITS'(col_r);
    row_d    = DIM_BITS'(row_r);
    col_e    = EXT_BITS'(col_r);
    row_e    = EXT_BITS'(row_r);
    t_e      = EXT_BITS'(border_thickness);
    in_frame = (col_d < w_dim) && (row_d < h_dim);
    in_box   = (box_w != '0) && (box_h != '0) && (col_d >= box_x) && (col_d < x_end) &&
               (row_d >= box_y) && (row_d < y_end);
    on_band  = (col_e < x_lo) || (col_e + t_e >= EXT_BITS'(x_end)) ||
               (row_e < y_lo) || (row_e + t_e >= EXT_BITS'(y_end));
    sel_c    = wpi_pkg::SEL_A;
    sc_c     = col_r;
    sr_c     = row_r;
    if (in_frame) begin
      case (transition_mode)
        wpi_pkg::MODE_IRIS: begin
          if (in_box) begin
            if (on_band) begin
              sel_c = wpi_pkg::SEL_BORDER;
              sc_c  = '0;
              sr_c  = '0;
            end else begin
              sel_c = wpi_pkg::SEL_B;
            end
          end
        end
        wpi_pkg::MODE_SLIDE_H, wpi_pkg::MODE_PUSH_H: begin
          if (col_d < box_w) begin
            sel_c = wpi_pkg::SEL_B;
            sc_c  = COORD_BITS'(w_rem + col_d);
          end else if (transition_mode == wpi_pkg::MODE_PUSH_H) begin
            sc_c = COORD_BITS'(col_d - box_w);
          end
        end
        wpi_pkg::MODE_SLIDE_V, wpi_pkg::MODE_PUSH_V: begin
          if (row_d < box_h) begin
            sel_c = wpi_pkg::SEL_B;
            sr_c  = COORD_BITS'(h_rem + row_d);
          end else if (transition_mode == wpi_pkg::MODE_PUSH_V) begin
            sr_c = COORD_BITS'(row_d - box_h);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r <= pixels.pixel_col;
      row_r <= pixels.pixel_row;
    end
    if (adv_out && s1_valid) begin
      out_sel  <= sel_c;
      out_col  <= sc_c;
      out_row  <= sr_c;
      out_fill <= (sel_c == wpi_pkg::SEL_BORDER) ? border_color : '0;
    end
  end

  assign results.valid         = out_valid;
  assign results.source_select = out_sel;
  assign results.source_col    = out_col;
  assign results.source_row    = out_row;
  assign results.fill_pixel    = out_fill;

endmodule

/* hw/rtl/wpi_checker.sv */
// port-level checks for the transition pixel selector, bound to the top level
module wpi_checker #(
  parameter int COORD_BITS = wpi_pkg::COORD_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wpi_pkg::SEL_BITS-1:0]   out_select,
  input logic [COORD_BITS-1:0]          out_col,
  input logic [COORD_BITS-1:0]          out_row,
  input logic [wpi_pkg::COLOR_BITS-1:0] out_fill
);

  // geometry is rebuilt after reset, so no pixel may be taken right away
  a_reset_recompute: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("pixel input ready right after reset");

  // a register write restarts the geometry sequencer
  a_cfg_recompute: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("pixel input ready right after a configuration transfer");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_select) && $stable(out_col) &&
    $stable(out_row) && $stable(out_fill))
    else $error("stalled result changed");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_select != wpi_pkg::SEL_BORDER |-> out_fill == '0)
    else $error("fill word set on an image result");

  a_border_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_select == wpi_pkg::SEL_BORDER |-> out_col == '0 && out_row == '0)
    else $error("border result with nonzero coordinate");

endmodule

bind wipe_push_iris_pixel_selector_top wpi_checker #(.COORD_BITS(COORD_BITS)) u_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .in_ready   (pixels.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_select (results.source_select),
  .out_col    (results.source_col),
  .out_row    (results.source_row),
  .out_fill   (results.fill_pixel)
);

/* dv/wipe_push_iris_pixel_selector_top_tb.sv */
// self-checking testbench for the wipe/push/iris pixel selector: random traffic checked per field
module wipe_push_iris_pixel_selector_top_tb;

  localparam int CB          = wpi_pkg::COORD_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [CB-1:0] col;
    logic [CB-1:0] row;
  } pixel_t;

  typedef struct packed {
    wpi_pkg::sel_t                  sel;
    logic [CB-1:0]                  col;
    logic [CB-1:0]                  row;
    logic [wpi_pkg::COLOR_BITS-1:0] fill;
  } decision_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bw;
    logic [31:0] bh;
  } geom_t;

  logic clk = 1'b0;
  logic rst;

  logic                               cfg_valid;
  logic [wpi_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [wpi_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                               px_valid = 1'b0;
  logic [CB-1:0]                      px_col = '0;
  logic [CB-1:0]                      px_row = '0;
  logic                               rx_ready = 1'b0;
  logic                               pix_taken = 1'b0;

  wpi_cfg_if                        cfg_ch();
  wpi_pixel_if  #(.COORD_BITS(CB))  pix_ch();
  wpi_result_if #(.COORD_BITS(CB))  res_ch();

  assign cfg_ch.valid     = cfg_valid;
  assign cfg_ch.index     = cfg_index;
  assign cfg_ch.data      = cfg_data;
  assign pix_ch.valid     = px_valid;
  assign pix_ch.pixel_col = px_col;
  assign pix_ch.pixel_row = px_row;
  assign res_ch.ready     = rx_ready;

  wipe_push_iris_pixel_selector_top #(.COORD_BITS(CB)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixels (pix_ch),
    .results(res_ch)
  );

  always #6 clk = ~clk;

  // register shadow, starts at the reset values
  logic [wpi_pkg::MODE_BITS-1:0]     cur_mode     = wpi_pkg::MODE_IRIS;
  logic [wpi_pkg::PROG_BITS-1:0]     cur_progress = wpi_pkg::RST_PROGRESS;
  logic [wpi_pkg::DIMREG_BITS-1:0]   cur_width    = wpi_pkg::RST_WIDTH;
  logic [wpi_pkg::DIMREG_BITS-1:0]   cur_height   = wpi_pkg::RST_HEIGHT;
  logic [wpi_pkg::PERMILLE_BITS-1:0] cur_cx       = wpi_pkg::RST_CENTER;
  logic [wpi_pkg::PERMILLE_BITS-1:0] cur_cy       = wpi_pkg::RST_CENTER;
  logic [wpi_pkg::THICK_BITS-1:0]    cur_thick    = wpi_pkg::RST_THICK;
  logic [wpi_pkg::COLOR_BITS-1:0]    cur_color    = wpi_pkg::RST_COLOR;

  pixel_t    pending_pixels[$];
  decision_t expected_decisions[$];
  int        pixels_queued = 0;
  int        pixels_taken  = 0;
  int        failures      = 0;
  int        quiet_cycles  = 0;

  int tx_style   = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int rx_style   = 0;
  int rx_left    = 0;
  bit rx_on      = 1'b1;
  int hold_left  = 0;

  function automatic geom_t frame_geometry();
    geom_t       g;
    logic [31:0] p;
    logic [31:0] cx;
    logic [31:0] cy;
    g.w = (cur_width == 0) ? 1 : (cur_width > (1 << CB)) ? (1 << CB) : cur_width;
    g.h = (cur_height == 0) ? 1 : (cur_height > (1 << CB)) ? (1 << CB) : cur_height;
    p   = (cur_progress > wpi_pkg::PROG_FULL) ? wpi_pkg::PROG_FULL : cur_progress;
    cx  = ((cur_cx > wpi_pkg::PERMILLE_FULL) ? wpi_pkg::PERMILLE_FULL : cur_cx) * g.w /
          wpi_pkg::PERMILLE_FULL;
    cy  = ((cur_cy > wpi_pkg::PERMILLE_FULL) ? wpi_pkg::PERMILLE_FULL : cur_cy) * g.h /
          wpi_pkg::PERMILLE_FULL;
    g.bx = (wpi_pkg::PROG_FULL - p) * cx / wpi_pkg::PROG_FULL;
    g.by = (wpi_pkg::PROG_FULL - p) * cy / wpi_pkg::PROG_FULL;
    // box size doubles as the slide offset of the matching axis
    g.bw = p * g.w / wpi_pkg::PROG_FULL;
    g.bh = p * g.h / wpi_pkg::PROG_FULL;
    return g;
  endfunction

  function automatic decision_t select_source(logic [CB-1:0] col, logic [CB-1:0] row);
    geom_t       g;
    decision_t   d;
    logic [31:0] dl;
    logic [31:0] dr;
    logic [31:0] dt;
    logic [31:0] db;
    g     = frame_geometry();
    d.sel = wpi_pkg::SEL_A;
    d.col = col;
    d.row = row;
    if (col < g.w && row < g.h) begin
      case (cur_mode)
        wpi_pkg::MODE_IRIS: begin
          if (g.bw != 0 && g.bh != 0 && col >= g.bx && col < g.bx + g.bw &&
              row >= g.by && row < g.by + g.bh) begin
            dl = col - g.bx;
            dr = g.bx + g.bw - 1 - col;
            dt = row - g.by;
            db = g.by + g.bh - 1 - row;
            if (dl < cur_thick || dr < cur_thick || dt < cur_thick || db < cur_thick) begin
              d.sel = wpi_pkg::SEL_BORDER;
              d.col = '0;
              d.row = '0;
            end else begin
              d.sel = wpi_pkg::SEL_B;
            end
          end
        end
        wpi_pkg::MODE_SLIDE_H, wpi_pkg::MODE_PUSH_H: begin
          if (col < g.bw) begin
            d.sel = wpi_pkg::SEL_B;
            d.col = CB'(g.w - g.bw + col);
          end else if (cur_mode == wpi_pkg::MODE_PUSH_H) begin
            d.col = CB'(col - g.bw);
          end
        end
        wpi_pkg::MODE_SLIDE_V, wpi_pkg::MODE_PUSH_V: begin
          if (row < g.bh) begin
            d.sel = wpi_pkg::SEL_B;
            d.row = CB'(g.h - g.bh + row);
          end else if (cur_mode == wpi_pkg::MODE_PUSH_V) begin
            d.row = CB'(row - g.bh);
          end
        end
        default: ;
      endcase
    end
    d.fill = (d.sel == wpi_pkg::SEL_BORDER) ? cur_color : '0;
    return d;
  endfunction

  // coordinate biased toward the region edges and band edges of one axis
  function automatic logic [CB-1:0] pick_coord(int dim, int lo, int hi, int band);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(dim - 1);
      4, 5, 6: begin
        case ($urandom_range(3))
          0:       v = lo;
          1:       v = lo + band;
          2:       v = hi - 1;
          default: v = hi - 1 - band;
        endcase
        v = v + int'($urandom_range(4)) - 2;
      end
      7: begin
        case ($urandom_range(3))
          0:       v = 0;
          1:       v = (1 << CB) - 1;
          2:       v = dim - 1;
          default: v = dim;
        endcase
      end
      default: v = $urandom_range((1 << CB) - 1);
    endcase
    if (v < 0) v = 0;
    if (v > (1 << CB) - 1) v = (1 << CB) - 1;
    return v[CB-1:0];
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'(1 << CB);
      2:       return 16'($urandom_range(8191, (1 << CB) + 1));
      3:       return 16'($urandom_range(1 << CB, 1));
      default: return 16'($urandom_range(80, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_permille();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'(wpi_pkg::PERMILLE_FULL);
      2:       return 16'($urandom_range(1023, wpi_pkg::PERMILLE_FULL + 1));
      default: return 16'($urandom_range(wpi_pkg::PERMILLE_FULL));
    endcase
  endfunction

  task automatic write_reg(input logic [wpi_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      wpi_pkg::REG_MODE:     cur_mode     = value[wpi_pkg::MODE_BITS-1:0];
      wpi_pkg::REG_PROGRESS: cur_progress = value[wpi_pkg::PROG_BITS-1:0];
      wpi_pkg::REG_WIDTH:    cur_width    = value[wpi_pkg::DIMREG_BITS-1:0];
      wpi_pkg::REG_HEIGHT:   cur_height   = value[wpi_pkg::DIMREG_BITS-1:0];
      wpi_pkg::REG_CENTER_X: cur_cx       = value[wpi_pkg::PERMILLE_BITS-1:0];
      wpi_pkg::REG_CENTER_Y: cur_cy       = value[wpi_pkg::PERMILLE_BITS-1:0];
      wpi_pkg::REG_THICK:    cur_thick    = value[wpi_pkg::THICK_BITS-1:0];
      wpi_pkg::REG_COLOR:    cur_color    = value[wpi_pkg::COLOR_BITS-1:0];
      default: ;
    endcase
  endtask

  // dirty puts junk above each register's width and hits an unused index
  task automatic set_regs(input logic [2:0] mode, input logic [15:0] prog, input logic [15:0] w,
                          input logic [15:0] h, input logic [15:0] cxp, input logic [15:0] cyp,
                          input logic [15:0] thick, input logic [15:0] color, input bit dirty);
    write_reg(wpi_pkg::REG_MODE,     dirty ? {13'($urandom), mode} : {13'd0, mode});
    write_reg(wpi_pkg::REG_PROGRESS, dirty ? {2'($urandom), prog[13:0]} : prog);
    write_reg(wpi_pkg::REG_WIDTH,    dirty ? {3'($urandom), w[12:0]} : w);
    write_reg(wpi_pkg::REG_HEIGHT,   dirty ? {3'($urandom), h[12:0]} : h);
    write_reg(wpi_pkg::REG_CENTER_X, dirty ? {6'($urandom), cxp[9:0]} : cxp);
    write_reg(wpi_pkg::REG_CENTER_Y, dirty ? {6'($urandom), cyp[9:0]} : cyp);
    write_reg(wpi_pkg::REG_THICK,    dirty ? {8'($urandom), thick[7:0]} : thick);
    write_reg(wpi_pkg::REG_COLOR,    color);
    if (dirty) write_reg(4'($urandom_range(15, 8)), 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // called just after a rising edge, before the phase's pixels are queued
  task automatic begin_traffic(input int hold);
    tx_style  = (hold > 0) ? 0 : $urandom_range(2);
    rx_style  = $urandom_range(3);
    hold_left = hold;
  endtask

  task automatic queue_pixel(input logic [CB-1:0] col, input logic [CB-1:0] row);
    pending_pixels.push_back('{col: col, row: row});
    pixels_queued++;
  endtask

  task automatic drain();
    do @(negedge clk); while (pixels_taken != pixels_queued || expected_decisions.size() != 0);
  endtask

  always @(negedge clk) begin : pixel_driver
    pixel_t nxt;
    if (rst) begin
      px_valid <= 1'b0;
    end else if (!px_valid || pix_taken) begin
      if (gap_left > 0 || pending_pixels.size() == 0) begin
        px_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        nxt = pending_pixels.pop_front();
        px_valid <= 1'b1;
        px_col   <= nxt.col;
        px_row   <= nxt.row;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(15);
          case (tx_style)
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(3);
            default: gap_left = $urandom_range(12);
          endcase
        end
      end
    end
  end

  always @(negedge clk) begin : result_receiver
    if (hold_left > 0) begin
      hold_left--;
      rx_ready <= 1'b0;
    end else begin
      if (rx_left > 0) begin
        rx_left--;
      end else begin
        rx_on = (rx_style == 0) ? 1'b1 : !rx_on;
        case (rx_style)
          0:       rx_left = 0;
          1:       rx_left = $urandom_range(3);
          2:       rx_left = rx_on ? $urandom_range(20, 5) : $urandom_range(2);
          default: rx_left = rx_on ? $urandom_range(2) : $urandom_range(10, 3);
        endcase
      end
      rx_ready <= rx_on;
    end
  end

  always @(posedge clk) begin : result_monitor
    decision_t want;
    pix_taken <= !rst && pix_ch.valid && pix_ch.ready;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_decisions.size() == 0) begin
        $error("unexpected result transfer: source_select %0d source_col %0d source_row %0d",
               res_ch.source_select, res_ch.source_col, res_ch.source_row);
        failures++;
      end else begin
        want = expected_decisions.pop_front();
        if (res_ch.source_select !== want.sel) begin
          $error("source_select: expected %0d, actual %0d", want.sel, res_ch.source_select);
          failures++;
        end
        if (res_ch.source_col !== want.col) begin
          $error("source_col: expected %0d, actual %0d", want.col, res_ch.source_col);
          failures++;
        end
        if (res_ch.source_row !== want.row) begin
          $error("source_row: expected %0d, actual %0d", want.row, res_ch.source_row);
          failures++;
        end
        if (res_ch.fill_pixel !== want.fill) begin
          $error("fill_pixel: expected %h, actual %h", want.fill, res_ch.fill_pixel);
          failures++;
        end
      end
    end
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      expected_decisions.push_back(select_source(pix_ch.pixel_col, pix_ch.pixel_row));
      pixels_taken++;
    end
    // watchdog on any transfer
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    geom_t       g;
    int          n;
    int          lo_c;
    int          lo_r;
    logic [15:0] v_prog;
    logic [15:0] v_thick;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: empty iris, frame edges
    begin_traffic(0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(639, 479);
    queue_pixel(640, 0);
    queue_pixel(0, 480);
    drain();

    // half-grown iris in a 64x48 frame: box cols 16..47, rows 12..35
    set_regs(wpi_pkg::MODE_IRIS, 5000, 64, 48, 500, 500, 2, 16'hA5A5, 1'b0);
    begin_traffic(0);
    queue_pixel(16, 12);
    queue_pixel(20, 20);
    queue_pixel(47, 35);
    queue_pixel(15, 20);
    queue_pixel(48, 20);
    queue_pixel(18, 14);
    drain();

    // quarter slides and pushes, offset 16 across and 12 down
    set_regs(wpi_pkg::MODE_SLIDE_H, 2500, 64, 48, 500, 500, 2, 16'h5A5A, 1'b0);
    begin_traffic(0);
    queue_pixel(15, 5);
    queue_pixel(16, 5);
    drain();
    set_regs(wpi_pkg::MODE_PUSH_H, 2500, 64, 48, 500, 500, 2, 16'h5A5A, 1'b0);
    begin_traffic(0);
    queue_pixel(0, 47);
    queue_pixel(63, 0);
    drain();
    set_regs(wpi_pkg::MODE_SLIDE_V, 2500, 64, 48, 500, 500, 2, 16'h5A5A, 1'b0);
    begin_traffic(0);
    queue_pixel(5, 11);
    queue_pixel(5, 12);
    drain();
    set_regs(wpi_pkg::MODE_PUSH_V, 2500, 64, 48, 500, 500, 2, 16'h5A5A, 1'b0);
    begin_traffic(0);
    queue_pixel(0, 12);
    queue_pixel(63, 47);
    drain();

    // unused mode code, saturated progress, degenerate and oversized frame
    set_regs(3'($urandom_range(7, 5)), 16383, 0, 8191, 1023, 1023, 255, 16'hFFFF, 1'b0);
    begin_traffic(0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();

    // full iris over the largest frame, no band
    set_regs(wpi_pkg::MODE_IRIS, 16383, 8191, 4096, 1023, 0, 0, 16'h1234, 1'b0);
    begin_traffic(0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();

    // full iris with the widest band
    set_regs(wpi_pkg::MODE_IRIS, 10000, 4096, 4096, 0, 1000, 255, 16'hBEEF, 1'b0);
    begin_traffic(0);
    queue_pixel(255, 300);
    queue_pixel(254, 2000);
    drain();

    for (int ph = 0; ph < 32; ph++) begin
      case ($urandom_range(9))
        0:       v_prog = 16'd0;
        1:       v_prog = 16'(wpi_pkg::PROG_FULL);
        2:       v_prog = 16'($urandom_range(16383, wpi_pkg::PROG_FULL + 1));
        default: v_prog = 16'($urandom_range(wpi_pkg::PROG_FULL));
      endcase
      case ($urandom_range(7))
        0:       v_thick = 16'd0;
        1:       v_thick = 16'd255;
        default: v_thick = 16'($urandom_range(12));
      endcase
      set_regs(($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4)),
               v_prog, pick_dim(), pick_dim(), pick_permille(), pick_permille(), v_thick,
               16'($urandom), $urandom_range(5) == 0);
      // long receiver hold-off on two phases so the pipeline backs up
      begin_traffic((ph == 6 || ph == 21) ? 250 : 0);
      g    = frame_geometry();
      lo_c = (cur_mode == wpi_pkg::MODE_IRIS) ? int'(g.bx) : 0;
      lo_r = (cur_mode == wpi_pkg::MODE_IRIS) ? int'(g.by) : 0;
      n    = $urandom_range(66, 40);
      repeat (n) begin
        queue_pixel(pick_coord(g.w, lo_c, lo_c + int'(g.bw), cur_thick),
                    pick_coord(g.h, lo_r, lo_r + int'(g.bh), cur_thick));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
